// ===== src/bpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Breath phase detector package
// Shared phase codes, register indexes and the configuration record.
// ----------------------------------------------------------------------------
package bpd_pkg;

   localparam int unsigned LIMIT_WIDTH   = 18;
   localparam int unsigned INS_CNT_WIDTH = 5;
   localparam int unsigned CNT_WIDTH     = 3;
   localparam int unsigned PHASE_WIDTH   = 3;
   localparam int unsigned CSR_IDX_WIDTH = 3;

   // phase codes
   localparam logic [PHASE_WIDTH-1:0] PH_NONE      = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_ERROR     = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_INS_START = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_INS_END   = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_EX_START  = 3'd4;
   localparam logic [PHASE_WIDTH-1:0] PH_EX_END    = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RISE_SLOPE    = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FALL_SLOPE    = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INS_END_SLOPE = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INS_CONFIRM   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_EX_CONFIRM    = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_END_CONFIRM   = 3'd5;

   typedef struct packed {
      logic signed [LIMIT_WIDTH-1:0]  rise_slope_limit;
      logic signed [LIMIT_WIDTH-1:0]  fall_slope_limit;
      logic signed [LIMIT_WIDTH-1:0]  ins_end_slope_limit;
      logic        [INS_CNT_WIDTH-1:0] ins_confirm_count;
      logic        [CNT_WIDTH-1:0]    ex_confirm_count;
      logic        [CNT_WIDTH-1:0]    end_confirm_count;
   } bpd_cfg_type;

endpackage

// ===== src/bpd_if.sv =====
// ----------------------------------------------------------------------------
// Breath phase detector channels
// Sample channel and phase result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpd_req_if #(parameter int unsigned SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] flow_mean;
   logic signed [SAMPLE_WIDTH-1:0] window_newest;
   logic signed [SAMPLE_WIDTH-1:0] window_previous;
   logic signed [SAMPLE_WIDTH-1:0] window_oldest;

   modport source (output valid, flow_mean, window_newest, window_previous,
                   window_oldest, input ready);
   modport sink (input valid, flow_mean, window_newest, window_previous,
                 window_oldest, output ready);
endinterface

interface bpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] phase;

   modport source (output valid, phase, input ready);
   modport sink (input valid, phase, output ready);
endinterface

// ===== src/breath_phase_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Breath phase detector
// Tracks the breathing phase from a stream of flow-mean samples.
// ----------------------------------------------------------------------------
// req_port carries one sample item: the flow mean and the newest, second
// newest and oldest entries of the mean window. rsp_port returns one
// item per sample holding the phase after that sample (0 none, 1 error,
// 2 ins start, 3 ins end, 4 ex start, 5 ex end).
// The csr_ port writes the slope limits and confirm counts; write only while
// no sample is in flight. Indexes above five are ignored.
// The sample is captured in an input register, then the phase update runs in
// one pass of logic and lands in the result register together with the
// tracker state.
// Throughput is one item per cycle while the receiver keeps rsp_port.ready
// high; the feedback through the tracker state closes in that single pass.
// Reset clears the phase to none, the arm flags and the counters, and loads
// the default limits and confirm counts. When the receiver stalls, the result
// register holds; the input register still takes one more item if it is
// empty, and req_port.ready then falls.
// ----------------------------------------------------------------------------
module breath_phase_detector_unit
   import bpd_pkg::*;
#(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   bpd_req_if.sink                  req_port,
   bpd_rsp_if.source                rsp_port,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [LIMIT_WIDTH-1:0]   csr_write_data
);

   bpd_cfg_type cfg;

   logic                           in_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] mean_ff;
   logic signed [SAMPLE_WIDTH-1:0] newest_ff;
   logic signed [SAMPLE_WIDTH-1:0] previous_ff;
   logic signed [SAMPLE_WIDTH-1:0] oldest_ff;
   logic                           out_valid_ff;
   logic [PHASE_WIDTH-1:0]         phase_ff;
   logic [PHASE_WIDTH-1:0]         phase_in;
   logic                           advance;
   logic                           req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_take = req_port.valid && req_port.ready;
   assign req_port.ready = !in_valid_ff || advance;

   bpd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bpd_tracker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_tracker (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .cfg             (cfg),
      .flow_mean       (mean_ff),
      .window_newest   (newest_ff),
      .window_previous (previous_ff),
      .window_oldest   (oldest_ff),
      .phase_in        (phase_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_port.ready) in_valid_ff <= req_port.valid;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // capture the sample item
   always_ff @(posedge clock) begin
      if (req_take) begin
         mean_ff     <= req_port.flow_mean;
         newest_ff   <= req_port.window_newest;
         previous_ff <= req_port.window_previous;
         oldest_ff   <= req_port.window_oldest;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) phase_ff <= phase_in;
   end

   assign rsp_port.valid = out_valid_ff;
   assign rsp_port.phase = phase_ff;

endmodule

// ===== src/bpd_csr.sv =====
// ----------------------------------------------------------------------------
// Breath phase detector configuration registers
// Write-only register file holding slope limits and confirm counts.
// ----------------------------------------------------------------------------
module bpd_csr
   import bpd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [LIMIT_WIDTH-1:0]   csr_write_data,
   output bpd_cfg_type              cfg
);

   bpd_cfg_type cfg_ff;
   bpd_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RISE_SLOPE:    cfg_in.rise_slope_limit    = csr_write_data;
            CSR_FALL_SLOPE:    cfg_in.fall_slope_limit    = csr_write_data;
            CSR_INS_END_SLOPE: cfg_in.ins_end_slope_limit = csr_write_data;
            CSR_INS_CONFIRM:   cfg_in.ins_confirm_count   = csr_write_data[INS_CNT_WIDTH-1:0];
            CSR_EX_CONFIRM:    cfg_in.ex_confirm_count    = csr_write_data[CNT_WIDTH-1:0];
            CSR_END_CONFIRM:   cfg_in.end_confirm_count   = csr_write_data[CNT_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_slope_limit    <= 18'sd90;
         cfg_ff.fall_slope_limit    <= -18'sd50;
         cfg_ff.ins_end_slope_limit <= 18'sd15;
         cfg_ff.ins_confirm_count   <= 5'd20;
         cfg_ff.ex_confirm_count    <= 3'd5;
         cfg_ff.end_confirm_count   <= 3'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/bpd_tracker.sv =====
// ----------------------------------------------------------------------------
// Breath phase detector tracker
// Holds the phase, arm flags and qualification counters and works out the
// phase that one sample leads to.
// ----------------------------------------------------------------------------
module bpd_tracker
   import bpd_pkg::*;
#(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  bpd_cfg_type                    cfg,
   input  logic signed [SAMPLE_WIDTH-1:0] flow_mean,
   input  logic signed [SAMPLE_WIDTH-1:0] window_newest,
   input  logic signed [SAMPLE_WIDTH-1:0] window_previous,
   input  logic signed [SAMPLE_WIDTH-1:0] window_oldest,
   output logic [PHASE_WIDTH-1:0]         phase_in
);

   localparam int unsigned DIFF_WIDTH = SAMPLE_WIDTH + 1;
   localparam int unsigned CMP_WIDTH  =
      (DIFF_WIDTH > LIMIT_WIDTH) ? DIFF_WIDTH : LIMIT_WIDTH;
   localparam logic [INS_CNT_WIDTH-1:0] RISE_TOP = '1;
   localparam logic [CNT_WIDTH-1:0]     CNT_TOP  = '1;

   logic [PHASE_WIDTH-1:0]         phase_ff;
   logic signed [SAMPLE_WIDTH-1:0] prev_mean_ff;
   logic                           ins_armed_ff;
   logic                           ex_armed_ff;
   logic [INS_CNT_WIDTH-1:0]       rise_count_ff;
   logic [CNT_WIDTH-1:0]           fall_count_ff;
   logic [CNT_WIDTH-1:0]           ins_end_count_ff;
   logic [CNT_WIDTH-1:0]           ex_end_count_ff;

   logic                           ins_armed_in;
   logic                           ex_armed_in;
   logic [INS_CNT_WIDTH-1:0]       rise_count_in;
   logic [CNT_WIDTH-1:0]           fall_count_in;
   logic [CNT_WIDTH-1:0]           ins_end_count_in;
   logic [CNT_WIDTH-1:0]           ex_end_count_in;

   logic signed [DIFF_WIDTH-1:0]   diff;
   logic signed [CMP_WIDTH-1:0]    diff_ext;
   logic                           mean_below;
   logic                           mean_above;
   logic                           cross_ins;
   logic                           cross_ex;

   assign diff       = DIFF_WIDTH'(window_newest) - DIFF_WIDTH'(window_oldest);
   assign diff_ext   = CMP_WIDTH'(diff);
   assign mean_below = flow_mean < window_newest;
   assign mean_above = flow_mean > window_newest;
   assign cross_ins  = (prev_mean_ff >= window_previous) && mean_below;
   assign cross_ex   = !cross_ins && (prev_mean_ff <= window_previous) && mean_above;

   always_comb begin
      phase_in         = phase_ff;
      ins_armed_in     = ins_armed_ff;
      ex_armed_in      = ex_armed_ff;
      rise_count_in    = rise_count_ff;
      fall_count_in    = fall_count_ff;
      ins_end_count_in = ins_end_count_ff;
      ex_end_count_in  = ex_end_count_ff;

      if (phase_ff == PH_NONE) begin
         // restart: clear the arm flags and counters and report error
         ins_armed_in     = 1'b0;
         ex_armed_in      = 1'b0;
         rise_count_in    = '0;
         fall_count_in    = '0;
         ins_end_count_in = '0;
         ex_end_count_in  = '0;
         phase_in         = PH_ERROR;
      end else begin
         if (cross_ins) begin
            ins_armed_in    = 1'b1;
            ex_armed_in     = 1'b0;
            fall_count_in   = '0;
            ex_end_count_in = '0;
         end else if (cross_ex) begin
            ex_armed_in      = 1'b1;
            ins_armed_in     = 1'b0;
            rise_count_in    = '0;
            ins_end_count_in = '0;
         end

         if (ins_armed_in && mean_below) begin
            if (diff_ext > CMP_WIDTH'(cfg.rise_slope_limit)) begin
               if (rise_count_in != RISE_TOP)
                  rise_count_in = rise_count_in + INS_CNT_WIDTH'(1);
            end else if (rise_count_in <= INS_CNT_WIDTH'(1)) begin
               rise_count_in = '0;
            end else begin
               rise_count_in = rise_count_in - INS_CNT_WIDTH'(1);
            end
            if (rise_count_in >= cfg.ins_confirm_count) begin
               rise_count_in = '0;
               ins_armed_in  = 1'b0;
               phase_in      = PH_INS_START;
            end
         end

         if (ex_armed_in && mean_above) begin
            if (diff_ext < CMP_WIDTH'(cfg.fall_slope_limit)) begin
               if (fall_count_in >= cfg.ex_confirm_count) begin
                  fall_count_in = '0;
                  ex_armed_in   = 1'b0;
                  phase_in      = PH_EX_START;
               end else begin
                  fall_count_in = fall_count_in + CNT_WIDTH'(1);
               end
            end else begin
               fall_count_in = '0;
            end
         end

         if (phase_in == PH_INS_START && mean_below &&
             diff_ext < CMP_WIDTH'(cfg.ins_end_slope_limit)) begin
            if (ins_end_count_in >= cfg.end_confirm_count) phase_in = PH_INS_END;
            if (ins_end_count_in != CNT_TOP)
               ins_end_count_in = ins_end_count_in + CNT_WIDTH'(1);
         end else begin
            ins_end_count_in = '0;
         end

         if (phase_in == PH_EX_START && mean_above && !diff[DIFF_WIDTH-1] &&
             diff != '0) begin
            if (ex_end_count_in >= cfg.end_confirm_count) phase_in = PH_EX_END;
            if (ex_end_count_in != CNT_TOP)
               ex_end_count_in = ex_end_count_in + CNT_WIDTH'(1);
         end else begin
            ex_end_count_in = '0;
         end

         // drop an arm whose sample lies on the wrong side
         if (ex_armed_in && mean_below) begin
            fall_count_in   = '0;
            ex_end_count_in = '0;
            ex_armed_in     = 1'b0;
         end
         if (ins_armed_in && mean_above) begin
            rise_count_in    = '0;
            ins_end_count_in = '0;
            ins_armed_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_NONE;
         prev_mean_ff     <= '0;
         ins_armed_ff     <= 1'b0;
         ex_armed_ff      <= 1'b0;
         rise_count_ff    <= '0;
         fall_count_ff    <= '0;
         ins_end_count_ff <= '0;
         ex_end_count_ff  <= '0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         prev_mean_ff     <= flow_mean;
         ins_armed_ff     <= ins_armed_in;
         ex_armed_ff      <= ex_armed_in;
         rise_count_ff    <= rise_count_in;
         fall_count_ff    <= fall_count_in;
         ins_end_count_ff <= ins_end_count_in;
         ex_end_count_ff  <= ex_end_count_in;
      end
   end

endmodule
